FILE: hdl/rmj_pkg.sv
// Shared types and constants for the radar measurement Jacobian pipeline.
package rmj_pkg;

    localparam int NLANE = 6;
    localparam int CFG_W = 32;
    localparam logic [CFG_W-1:0] MIN_RANGE_SQ_RST = 32'd429497;

    // Lane codes: one divider lane per Jacobian entry.
    localparam int L_RNG_X  = 0;
    localparam int L_RNG_Y  = 1;
    localparam int L_BRG_X  = 2;
    localparam int L_BRG_Y  = 3;
    localparam int L_RATE_X = 4;
    localparam int L_RATE_Y = 5;

    // Control that travels with each item down the chain.
    typedef struct packed {
        logic             valid;
        logic             near;
        logic [NLANE-1:0] neg;
        logic [NLANE-1:0] ovf;
    } t_tag;

endpackage

FILE: hdl/rmj_sqrt_cell.sv
// One cell of the integer square root chain: settles one root bit per stage.
module rmj_sqrt_cell
    import rmj_pkg::*;
#(
    parameter int W   = 32,
    parameter int BIT = 0,
    parameter int PW  = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en_next,
    output logic            o_en,
    input  t_tag            i_tag,
    output t_tag            o_tag,
    input  logic [2*W-1:0]  i_s,
    output logic [2*W-1:0]  o_s,
    input  logic [W+1:0]    i_rem,
    output logic [W+1:0]    o_rem,
    input  logic [W-1:0]    i_root,
    output logic [W-1:0]    o_root,
    input  logic [PW-1:0]   i_pass,
    output logic [PW-1:0]   o_pass
);

    t_tag           r_tag;
    logic [2*W-1:0] r_s;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [PW-1:0]  r_pass;

    logic [W+1:0]   rem_sh;
    logic [W+1:0]   trial;
    logic           ge;
    logic [W+1:0]   n_rem;
    logic [W-1:0]   n_root;

    assign o_en   = !r_tag.valid || i_en_next;
    assign rem_sh = {i_rem[W-1:0], i_s[2*BIT +: 2]};
    assign trial  = {i_root, 2'b01};
    assign ge     = rem_sh >= trial;
    assign n_rem  = ge ? (rem_sh - trial) : rem_sh;
    assign n_root = {i_root[W-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (o_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_s    <= i_s;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pass <= i_pass;
        end
    end

    assign o_tag  = r_tag;
    assign o_s    = r_s;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pass = r_pass;

endmodule

FILE: hdl/rmj_div_cell.sv
// One cell of the six-lane restoring divider chain: one quotient bit per lane.
module rmj_div_cell
    import rmj_pkg::*;
#(
    parameter int W   = 32,
    parameter int XW  = 128,
    parameter int BIT = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en_next,
    output logic                       o_en,
    input  t_tag                       i_tag,
    output t_tag                       o_tag,
    input  logic [NLANE-1:0][XW-1:0]   i_rem,
    output logic [NLANE-1:0][XW-1:0]   o_rem,
    input  logic [NLANE-1:0][XW-1:0]   i_den,
    output logic [NLANE-1:0][XW-1:0]   o_den,
    input  logic [NLANE-1:0][W-1:0]    i_q,
    output logic [NLANE-1:0][W-1:0]    o_q
);

    t_tag                     r_tag;
    logic [NLANE-1:0][XW-1:0] r_rem;
    logic [NLANE-1:0][XW-1:0] r_den;
    logic [NLANE-1:0][W-1:0]  r_q;

    logic [NLANE-1:0][XW-1:0] dsh;
    logic [NLANE-1:0]         take;
    logic [NLANE-1:0][XW-1:0] n_rem;
    logic [NLANE-1:0][W-1:0]  n_q;

    assign o_en = !r_tag.valid || i_en_next;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            dsh[l]   = i_den[l] << BIT;
            take[l]  = i_rem[l] >= dsh[l];
            n_rem[l] = take[l] ? (i_rem[l] - dsh[l]) : i_rem[l];
            n_q[l]   = {i_q[l][W-2:0], take[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (o_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_q   <= n_q;
        end
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

FILE: hdl/radar_measurement_jacobian.sv
// Top level of the radar range/bearing/range-rate Jacobian pipeline.
//
// Takes one state (px, py, vx, vy, signed fixed point with FRAC_BITS fraction
// bits in DATA_WIDTH bits) per transfer and returns the six distinct nonzero
// Jacobian entries, each the exact quotient rounded to nearest (ties away
// from zero) and clipped to the signed DATA_WIDTH range, plus a near-origin
// flag and a clip flag. One item is accepted every cycle unless back-pressure
// has filled every stage; each passes through stages A to E, the square root
// chain (one root bit per cell), stages G to I, the six-lane divider chain
// (one quotient bit per cell) and stages R and O. Every stage holds its item
// under back-pressure and empty stages keep filling, so the input stays ready
// while a result waits until all 2*DATA_WIDTH+10 stages hold an item.
// min_range_squared may only be written while no item is in flight; it
// resets to about 0.0001 m^2. No clearing pass follows reset.
module radar_measurement_jacobian
    import rmj_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // state transfer in
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_pos_x,
    input  logic signed [DATA_WIDTH-1:0] i_pos_y,
    input  logic signed [DATA_WIDTH-1:0] i_vel_x,
    input  logic signed [DATA_WIDTH-1:0] i_vel_y,
    // Jacobian transfer out
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_d_range_d_px,
    output logic signed [DATA_WIDTH-1:0] o_d_range_d_py,
    output logic signed [DATA_WIDTH-1:0] o_d_bearing_d_px,
    output logic signed [DATA_WIDTH-1:0] o_d_bearing_d_py,
    output logic signed [DATA_WIDTH-1:0] o_d_rate_d_px,
    output logic signed [DATA_WIDTH-1:0] o_d_rate_d_py,
    output logic                         o_near_origin,
    output logic                         o_saturated,
    // threshold register write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int XW = 4 * W;               // divider remainder width
    localparam int PW = 8 * W;               // {m0, m1, n4, n5} through sqrt
    localparam int CW = (2 * W > CFG_W) ? 2 * W : CFG_W;

    // ---------------- threshold register ----------------
    logic [CFG_W-1:0] r_min_range_sq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range_sq <= MIN_RANGE_SQ_RST;
        end else if (i_cfg_valid) begin
            r_min_range_sq <= i_cfg_data;
        end
    end

    // ---------------- stage enables ----------------
    // A stage loads when it is empty or its successor loads.
    t_tag r_tag_a, r_tag_b, r_tag_c, r_tag_d, r_tag_e;
    t_tag r_tag_g, r_tag_h, r_tag_i, r_tag_r, r_tag_o;
    logic en_a, en_b, en_c, en_d, en_e, en_g, en_h, en_i, en_r, en_o;

    logic sq_en [W+1];
    logic dv_en [W+1];

    assign en_o = !r_tag_o.valid || i_out_ready;
    assign en_r = !r_tag_r.valid || en_o;
    assign dv_en[W] = en_r;
    assign en_i = !r_tag_i.valid || dv_en[0];
    assign en_h = !r_tag_h.valid || en_i;
    assign en_g = !r_tag_g.valid || en_h;
    assign sq_en[W] = en_g;
    assign en_e = !r_tag_e.valid || sq_en[0];
    assign en_d = !r_tag_d.valid || en_e;
    assign en_c = !r_tag_c.valid || en_d;
    assign en_b = !r_tag_b.valid || en_c;
    assign en_a = !r_tag_a.valid || en_b;

    assign o_in_ready = en_a;

    // ---------------- stage A: sign and magnitude ----------------
    logic [3:0]   r_ng_a;
    logic [W-1:0] r_m0_a, r_m1_a, r_m2_a, r_m3_a;
    t_tag         n_tag_a;

    always_comb begin
        n_tag_a       = '0;
        n_tag_a.valid = i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
        end else if (en_a) begin
            r_tag_a <= n_tag_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_ng_a <= {i_vel_y[W-1], i_vel_x[W-1], i_pos_y[W-1], i_pos_x[W-1]};
            r_m0_a <= i_pos_x[W-1] ? W'(-i_pos_x) : W'(i_pos_x);
            r_m1_a <= i_pos_y[W-1] ? W'(-i_pos_y) : W'(i_pos_y);
            r_m2_a <= i_vel_x[W-1] ? W'(-i_vel_x) : W'(i_vel_x);
            r_m3_a <= i_vel_y[W-1] ? W'(-i_vel_y) : W'(i_vel_y);
        end
    end

    // ---------------- stage B: squares and cross products ----------------
    logic [3:0]     r_ng_b;
    logic [W-1:0]   r_m0_b, r_m1_b;
    logic [2*W-1:0] r_p00_b, r_p11_b, r_t1_b, r_t2_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_b <= '0;
        end else if (en_b) begin
            r_tag_b <= r_tag_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_ng_b  <= r_ng_a;
            r_m0_b  <= r_m0_a;
            r_m1_b  <= r_m1_a;
            r_p00_b <= {{W{1'b0}}, r_m0_a} * {{W{1'b0}}, r_m0_a};
            r_p11_b <= {{W{1'b0}}, r_m1_a} * {{W{1'b0}}, r_m1_a};
            r_t1_b  <= {{W{1'b0}}, r_m2_a} * {{W{1'b0}}, r_m1_a};
            r_t2_b  <= {{W{1'b0}}, r_m3_a} * {{W{1'b0}}, r_m0_a};
        end
    end

    // ---------------- stage C: squared range, cross term, near test ----------------
    logic [W-1:0]   r_m0_c, r_m1_c;
    logic [2*W-1:0] r_s_c, r_cross_c;
    logic [2*W-1:0] s_sum;
    logic           n1, n2, t_ge, ncross;
    logic [2*W-1:0] cross_mag;
    t_tag           n_tag_c;

    assign s_sum = r_p00_b + r_p11_b;
    assign n1    = r_ng_b[2] ^ r_ng_b[1];
    assign n2    = !(r_ng_b[3] ^ r_ng_b[0]);
    assign t_ge  = r_t1_b >= r_t2_b;

    // cross term vx*py - vy*px kept as sign and magnitude
    always_comb begin
        if (n1 == n2) begin
            cross_mag = r_t1_b + r_t2_b;
            ncross    = n1;
        end else if (t_ge) begin
            cross_mag = r_t1_b - r_t2_b;
            ncross    = n1;
        end else begin
            cross_mag = r_t2_b - r_t1_b;
            ncross    = n2;
        end
    end

    always_comb begin
        n_tag_c                = r_tag_b;
        n_tag_c.near           = (s_sum == '0) || (CW'(s_sum) < CW'(r_min_range_sq));
        n_tag_c.neg[L_RNG_X]   = r_ng_b[0];
        n_tag_c.neg[L_RNG_Y]   = r_ng_b[1];
        n_tag_c.neg[L_BRG_X]   = !r_ng_b[1];
        n_tag_c.neg[L_BRG_Y]   = r_ng_b[0];
        n_tag_c.neg[L_RATE_X]  = r_ng_b[1] ^ ncross;
        n_tag_c.neg[L_RATE_Y]  = r_ng_b[0] ^ !ncross;
        n_tag_c.ovf            = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_c <= '0;
        end else if (en_c) begin
            r_tag_c <= n_tag_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_m0_c    <= r_m0_b;
            r_m1_c    <= r_m1_b;
            r_s_c     <= s_sum;
            r_cross_c <= cross_mag;
        end
    end

    // ---------------- stage D: numerator partial products ----------------
    logic [W-1:0]   r_m0_d, r_m1_d;
    logic [2*W-1:0] r_s_d;
    logic [2*W-1:0] r_a_lo_d, r_a_hi_d, r_b_lo_d, r_b_hi_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_d <= '0;
        end else if (en_d) begin
            r_tag_d <= r_tag_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_m0_d   <= r_m0_c;
            r_m1_d   <= r_m1_c;
            r_s_d    <= r_s_c;
            r_a_lo_d <= {{W{1'b0}}, r_m1_c} * {{W{1'b0}}, r_cross_c[W-1:0]};
            r_a_hi_d <= {{W{1'b0}}, r_m1_c} * {{W{1'b0}}, r_cross_c[2*W-1:W]};
            r_b_lo_d <= {{W{1'b0}}, r_m0_c} * {{W{1'b0}}, r_cross_c[W-1:0]};
            r_b_hi_d <= {{W{1'b0}}, r_m0_c} * {{W{1'b0}}, r_cross_c[2*W-1:W]};
        end
    end

    // ---------------- stage E: numerator sums ----------------
    logic [W-1:0]   r_m0_e, r_m1_e;
    logic [2*W-1:0] r_s_e;
    logic [3*W-1:0] r_n4_e, r_n5_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_e <= '0;
        end else if (en_e) begin
            r_tag_e <= r_tag_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_m0_e <= r_m0_d;
            r_m1_e <= r_m1_d;
            r_s_e  <= r_s_d;
            r_n4_e <= ({r_a_hi_d, {W{1'b0}}}) + (3*W)'(r_a_lo_d);
            r_n5_e <= ({r_b_hi_d, {W{1'b0}}}) + (3*W)'(r_b_lo_d);
        end
    end

    // ---------------- square root chain ----------------
    t_tag           sq_tag  [W+1];
    logic [2*W-1:0] sq_s    [W+1];
    logic [W+1:0]   sq_rem  [W+1];
    logic [W-1:0]   sq_root [W+1];
    logic [PW-1:0]  sq_pass [W+1];

    assign sq_tag[0]  = r_tag_e;
    assign sq_s[0]    = r_s_e;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pass[0] = {r_m0_e, r_m1_e, r_n4_e, r_n5_e};

    for (genvar g = 0; g < W; g++) begin : g_sqrt
        rmj_sqrt_cell #(
            .W   (W),
            .BIT (W - 1 - g),
            .PW  (PW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en_next (sq_en[g+1]),
            .o_en      (sq_en[g]),
            .i_tag     (sq_tag[g]),
            .o_tag     (sq_tag[g+1]),
            .i_s       (sq_s[g]),
            .o_s       (sq_s[g+1]),
            .i_rem     (sq_rem[g]),
            .o_rem     (sq_rem[g+1]),
            .i_root    (sq_root[g]),
            .o_root    (sq_root[g+1]),
            .i_pass    (sq_pass[g]),
            .o_pass    (sq_pass[g+1])
        );
    end

    // ---------------- stage G: S*rho partial products ----------------
    logic [W-1:0]   r_m0_g, r_m1_g, r_rho_g;
    logic [2*W-1:0] r_s_g, r_d_lo_g, r_d_hi_g;
    logic [3*W-1:0] r_n4_g, r_n5_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_g <= '0;
        end else if (en_g) begin
            r_tag_g <= sq_tag[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            {r_m0_g, r_m1_g, r_n4_g, r_n5_g} <= sq_pass[W];
            r_rho_g  <= sq_root[W];
            r_s_g    <= sq_s[W];
            r_d_lo_g <= {{W{1'b0}}, sq_s[W][W-1:0]} * {{W{1'b0}}, sq_root[W]};
            r_d_hi_g <= {{W{1'b0}}, sq_s[W][2*W-1:W]} * {{W{1'b0}}, sq_root[W]};
        end
    end

    // ---------------- stage H: rho cubed ----------------
    logic [W-1:0]   r_m0_h, r_m1_h, r_rho_h;
    logic [2*W-1:0] r_s_h;
    logic [3*W-1:0] r_n4_h, r_n5_h, r_den3_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_h <= '0;
        end else if (en_h) begin
            r_tag_h <= r_tag_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_h) begin
            r_m0_h   <= r_m0_g;
            r_m1_h   <= r_m1_g;
            r_rho_h  <= r_rho_g;
            r_s_h    <= r_s_g;
            r_n4_h   <= r_n4_g;
            r_n5_h   <= r_n5_g;
            r_den3_h <= ({r_d_hi_g, {W{1'b0}}}) + (3*W)'(r_d_lo_g);
        end
    end

    // ---------------- stage I: lane setup and overflow precheck ----------------
    // A quotient of 2^W or more always clips, so the chain only builds W bits.
    logic [NLANE-1:0][XW-1:0] lane_num, lane_den;
    logic [NLANE-1:0][XW-1:0] r_num_i, r_den_i;
    t_tag                     n_tag_i;

    always_comb begin
        lane_num[L_RNG_X]  = XW'(r_m0_h) << F;
        lane_den[L_RNG_X]  = XW'(r_rho_h);
        lane_num[L_RNG_Y]  = XW'(r_m1_h) << F;
        lane_den[L_RNG_Y]  = XW'(r_rho_h);
        lane_num[L_BRG_X]  = XW'(r_m1_h) << (2 * F);
        lane_den[L_BRG_X]  = XW'(r_s_h);
        lane_num[L_BRG_Y]  = XW'(r_m0_h) << (2 * F);
        lane_den[L_BRG_Y]  = XW'(r_s_h);
        lane_num[L_RATE_X] = XW'(r_n4_h) << F;
        lane_den[L_RATE_X] = XW'(r_den3_h);
        lane_num[L_RATE_Y] = XW'(r_n5_h) << F;
        lane_den[L_RATE_Y] = XW'(r_den3_h);
        n_tag_i = r_tag_h;
        for (int l = 0; l < NLANE; l++) begin
            n_tag_i.ovf[l] = lane_num[l] >= (lane_den[l] << W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_i <= '0;
        end else if (en_i) begin
            r_tag_i <= n_tag_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_i) begin
            r_num_i <= lane_num;
            r_den_i <= lane_den;
        end
    end

    // ---------------- divider chain ----------------
    t_tag                     dv_tag [W+1];
    logic [NLANE-1:0][XW-1:0] dv_rem [W+1];
    logic [NLANE-1:0][XW-1:0] dv_den [W+1];
    logic [NLANE-1:0][W-1:0]  dv_q   [W+1];

    assign dv_tag[0] = r_tag_i;
    assign dv_rem[0] = r_num_i;
    assign dv_den[0] = r_den_i;
    assign dv_q[0]   = '0;

    for (genvar g = 0; g < W; g++) begin : g_div
        rmj_div_cell #(
            .W   (W),
            .XW  (XW),
            .BIT (W - 1 - g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en_next (dv_en[g+1]),
            .o_en      (dv_en[g]),
            .i_tag     (dv_tag[g]),
            .o_tag     (dv_tag[g+1]),
            .i_rem     (dv_rem[g]),
            .o_rem     (dv_rem[g+1]),
            .i_den     (dv_den[g]),
            .o_den     (dv_den[g+1]),
            .i_q       (dv_q[g]),
            .o_q       (dv_q[g+1])
        );
    end

    // ---------------- stage R: round to nearest, ties away ----------------
    logic [NLANE-1:0][W:0] r_qr_r;
    logic [NLANE-1:0]      up;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            up[l] = {dv_rem[W][l], 1'b0} >= {1'b0, dv_den[W][l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_r <= '0;
        end else if (en_r) begin
            r_tag_r <= dv_tag[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_r) begin
            for (int l = 0; l < NLANE; l++) begin
                r_qr_r[l] <= {1'b0, dv_q[W][l]} + (W+1)'(up[l]);
            end
        end
    end

    // ---------------- stage O: clip, sign, output register ----------------
    localparam logic [W:0] LIM_NEG = (W+1)'(1) << (W - 1);
    localparam logic [W:0] LIM_POS = LIM_NEG - (W+1)'(1);

    logic [NLANE-1:0][W-1:0] n_val;
    logic [NLANE-1:0][W-1:0] r_val_o;
    logic [NLANE-1:0]        over;
    logic [NLANE-1:0][W:0]   lim;
    logic [NLANE-1:0][W:0]   mag;
    logic                    r_sat_o;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            lim[l]  = r_tag_r.neg[l] ? LIM_NEG : LIM_POS;
            over[l] = r_tag_r.ovf[l] || (r_qr_r[l] > lim[l]);
            mag[l]  = over[l] ? lim[l] : r_qr_r[l];
            if (r_tag_r.near) begin
                n_val[l] = '0;
            end else if (r_tag_r.neg[l]) begin
                n_val[l] = W'(-mag[l][W-1:0]);
            end else begin
                n_val[l] = mag[l][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_o <= '0;
        end else if (en_o) begin
            r_tag_o <= r_tag_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_val_o <= n_val;
            r_sat_o <= !r_tag_r.near && (over != '0);
        end
    end

    assign o_out_valid      = r_tag_o.valid;
    assign o_d_range_d_px   = r_val_o[L_RNG_X];
    assign o_d_range_d_py   = r_val_o[L_RNG_Y];
    assign o_d_bearing_d_px = r_val_o[L_BRG_X];
    assign o_d_bearing_d_py = r_val_o[L_BRG_Y];
    assign o_d_rate_d_px    = r_val_o[L_RATE_X];
    assign o_d_rate_d_py    = r_val_o[L_RATE_Y];
    assign o_near_origin    = r_tag_o.near;
    assign o_saturated      = r_sat_o;

endmodule
